// ===== rtl/marcs_pkg.sv =====
// shared types, constants and helpers of the range count scan unit
package marcs_pkg;

    // store geometry
    localparam int MAX_RECORDS = 4096;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    // attribute and bound widths
    localparam int ATTR_MAX    = 3;
    localparam int ATTR_COUNT  = 3;
    localparam int ATTR_W      = 24;
    localparam int BOUND_W     = 32;
    localparam int OUT_W       = 13;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // configuration register map
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_A = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_A = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_B = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_B = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_C = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_C = 3'd5;
    localparam logic [BOUND_W-1:0] BOUND_LOW_RST  = 32'h0000_0000;
    localparam logic [BOUND_W-1:0] BOUND_HIGH_RST = 32'hffff_ffff;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic [ATTR_MAX-1:0][ATTR_W-1:0]   t_record;
    typedef logic [2*ATTR_MAX-1:0][BOUND_W-1:0] t_bounds;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ATTR_W-1:0] attr_a;
        logic [ATTR_W-1:0] attr_b;
        logic [ATTR_W-1:0] attr_c;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] match_count;
        logic [OUT_W-1:0] records_held;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic scan_start;
        logic scan_issue;
        logic result_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic issue_done;
        logic pipe_busy;
        logic out_busy;
    } t_stat;

    // clamp a count to the output field
    function automatic logic [OUT_W-1:0] sat_out(input logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        if (w > {{CNT_W{1'b0}}, OUT_MAX}) begin
            return OUT_MAX;
        end
        return w[OUT_W-1:0];
    endfunction

    // record lies inside every active inclusive range
    function automatic logic rec_inside(input t_record rec, input t_bounds bnd);
        logic ok;
        logic [BOUND_W-1:0] v;
        ok = 1'b1;
        for (int a = 0; a < ATTR_COUNT; a++) begin
            v = {{(BOUND_W-ATTR_W){1'b0}}, rec[a]};
            if (v < bnd[2*a] || v > bnd[2*a+1]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== rtl/multi_attribute_range_count_scan_unit.sv =====
// top level: range count scan over a stored record table
// loads, clears and unknown codes do not stall the input; a query stalls input until its result loads
// a query reads the stored records one a cycle from the read port; once the read, compare and
//   count stages drain, the result loads into the output register unless an earlier result is
//   still held there by an output stall
// synchronous active-low reset empties the store and restores the bounds
module multi_attribute_range_count_scan_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [marcs_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [marcs_pkg::BOUND_W-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  marcs_pkg::t_in_word             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output marcs_pkg::t_out_word            o_out_word
);

    marcs_pkg::t_cmd  cmd;
    marcs_pkg::t_stat stat;

    // sequencing
    marcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_word.operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    // storage and compare
    marcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/marcs_ctrl.sv =====
// controller state machine: accepts words and sequences the store scan
module marcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_operation,
    input  marcs_pkg::t_stat    i_stat,
    output marcs_pkg::t_cmd     o_cmd,
    output logic                o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        marcs_pkg::OP_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        marcs_pkg::OP_QUERY: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                        marcs_pkg::OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_stat.issue_done) begin
                    o_cmd.scan_issue = 1'b1;
                end else if (!i_stat.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/marcs_dp.sv =====
// datapath: bound registers, record memory, scan pipeline and output register
module marcs_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [marcs_pkg::REG_IDX_W-1:0]       i_cfg_idx,
    input  logic [marcs_pkg::BOUND_W-1:0]         i_cfg_data,
    input  marcs_pkg::t_in_word                   i_in_word,
    input  marcs_pkg::t_cmd                       i_cmd,
    input  logic                                  i_out_stall,
    output marcs_pkg::t_stat                      o_stat,
    output logic                                  o_out_valid,
    output marcs_pkg::t_out_word                  o_out_word
);

    marcs_pkg::t_bounds   r_bound;
    marcs_pkg::t_record   r_mem [marcs_pkg::MAX_RECORDS];
    marcs_pkg::t_record   r_rd_data;
    marcs_pkg::t_record   wr_rec;
    logic [marcs_pkg::CNT_W-1:0] r_total;
    logic [marcs_pkg::CNT_W-1:0] r_rd_ptr;
    logic [marcs_pkg::CNT_W-1:0] r_tally;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_hit;
    logic                 r_out_valid;
    marcs_pkg::t_out_word r_out_word;
    logic                 full;
    logic                 do_write;

    assign full     = (r_total == marcs_pkg::CNT_W'(marcs_pkg::MAX_RECORDS));
    assign do_write = i_cmd.load && !full;

    always_comb begin
        wr_rec    = '0;
        wr_rec[0] = i_in_word.attr_a;
        wr_rec[1] = i_in_word.attr_b;
        wr_rec[2] = i_in_word.attr_c;
    end

    assign o_stat.issue_done = (r_rd_ptr == r_total);
    assign o_stat.pipe_busy  = r_v1 || r_v2;
    assign o_stat.out_busy   = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

    // bound registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 2*marcs_pkg::ATTR_MAX; r++) begin
                r_bound[r] <= (r % 2 == 0) ? marcs_pkg::BOUND_LOW_RST
                                           : marcs_pkg::BOUND_HIGH_RST;
            end
        end else if (i_cfg_we &&
                     i_cfg_idx < marcs_pkg::REG_IDX_W'(marcs_pkg::NUM_REGS)) begin
            r_bound[i_cfg_idx] <= i_cfg_data;
        end
    end

    // record memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_total[marcs_pkg::ADDR_W-1:0]] <= wr_rec;
        end
        if (i_cmd.scan_issue) begin
            r_rd_data <= r_mem[r_rd_ptr[marcs_pkg::ADDR_W-1:0]];
        end
    end

    // record count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.clear) begin
            r_total <= '0;
        end else if (do_write) begin
            r_total <= r_total + 1'b1;
        end
    end

    // scan pipeline: read, compare, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_hit    <= 1'b0;
            r_tally  <= '0;
        end else if (i_cmd.scan_start || i_cmd.clear) begin
            r_rd_ptr <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_hit    <= 1'b0;
            r_tally  <= '0;
        end else begin
            r_v1  <= i_cmd.scan_issue;
            r_v2  <= r_v1;
            r_hit <= r_v1 && marcs_pkg::rec_inside(r_rd_data, r_bound);
            if (i_cmd.scan_issue) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (r_v2 && r_hit) begin
                r_tally <= r_tally + 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_out_word.match_count  <= marcs_pkg::sat_out(r_tally);
            r_out_word.records_held <= marcs_pkg::sat_out(r_total);
        end
    end

endmodule

// ===== rtl/marcs_chk.sv =====
// port-level checker for the range count scan unit, bound to the top level
module marcs_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  marcs_pkg::t_in_word             i_in_word,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  marcs_pkg::t_out_word            o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // a query blocks the input side while it scans
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.operation == marcs_pkg::OP_QUERY)
        |=> o_in_stall)
        else $error("input taken during a scan");

    // a new result only appears at the end of a scan
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a scan");

    // count never exceeds the records held
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.match_count <= o_out_word.records_held))
        else $error("match count above records held");

    // store never reports more than it can hold
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({19'd0, o_out_word.records_held} <= marcs_pkg::MAX_RECORDS))
        else $error("records held above capacity");

endmodule

bind multi_attribute_range_count_scan_unit marcs_chk u_marcs_chk (.*);

// ===== test/multi_attribute_range_count_scan_unit_test.sv =====
// self-checking testbench for the multi-attribute range count scan unit
module multi_attribute_range_count_scan_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // codes the block has no meaning for
    localparam logic [1:0]                      OP_UNUSED    = 2'd3;
    localparam logic [marcs_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [marcs_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [marcs_pkg::ATTR_W-1:0]  ATTR_ONES = '1;
    localparam logic [marcs_pkg::BOUND_W-1:0] ATTR_TOP  = 32'h00ff_ffff;

    // run shape
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PHASE_WORDS   = 18;
    localparam int FILL_WORDS    = 24;
    localparam int RAND_WORDS    = 80;
    localparam int RAND_RESULTS  = 20;

    // predicted store, bounds and counts still owed by the block
    class range_count_tracker;
        typedef struct {
            logic [marcs_pkg::ATTR_W-1:0] a;
            logic [marcs_pkg::ATTR_W-1:0] b;
            logic [marcs_pkg::ATTR_W-1:0] c;
        } t_held_rec;

        t_held_rec                     held[$];
        logic [marcs_pkg::BOUND_W-1:0] bounds[marcs_pkg::NUM_REGS];
        marcs_pkg::t_out_word          due_counts[$];
        int                            errors;

        function new();
            bounds[marcs_pkg::REG_LOWER_A] = marcs_pkg::BOUND_LOW_RST;
            bounds[marcs_pkg::REG_UPPER_A] = marcs_pkg::BOUND_HIGH_RST;
            bounds[marcs_pkg::REG_LOWER_B] = marcs_pkg::BOUND_LOW_RST;
            bounds[marcs_pkg::REG_UPPER_B] = marcs_pkg::BOUND_HIGH_RST;
            bounds[marcs_pkg::REG_LOWER_C] = marcs_pkg::BOUND_LOW_RST;
            bounds[marcs_pkg::REG_UPPER_C] = marcs_pkg::BOUND_HIGH_RST;
            errors = 0;
        endfunction

        function void write_reg(input logic [marcs_pkg::REG_IDX_W-1:0] idx,
                                input logic [marcs_pkg::BOUND_W-1:0] val);
            if (idx <= marcs_pkg::REG_UPPER_C) begin
                bounds[idx] = val;
            end
        endfunction

        // 24-bit attribute against full-width inclusive bounds
        function bit in_window(input logic [marcs_pkg::ATTR_W-1:0] v,
                               input logic [marcs_pkg::BOUND_W-1:0] lo,
                               input logic [marcs_pkg::BOUND_W-1:0] hi);
            logic [marcs_pkg::BOUND_W-1:0] wide;
            wide = {{(marcs_pkg::BOUND_W-marcs_pkg::ATTR_W){1'b0}}, v};
            return (wide >= lo) && (wide <= hi);
        endfunction

        function logic [marcs_pkg::OUT_W-1:0] clamp_count(input int n);
            logic [31:0] u;
            u = n;
            if (u > {19'd0, marcs_pkg::OUT_MAX}) begin
                return marcs_pkg::OUT_MAX;
            end
            return u[marcs_pkg::OUT_W-1:0];
        endfunction

        // accepted input word
        function void take_word(input marcs_pkg::t_in_word w);
            t_held_rec            r;
            marcs_pkg::t_out_word due;
            int                   hits;
            case (w.operation)
                marcs_pkg::OP_LOAD: begin
                    if (held.size() < marcs_pkg::MAX_RECORDS) begin
                        r.a = w.attr_a;
                        r.b = w.attr_b;
                        r.c = w.attr_c;
                        held.push_back(r);
                    end
                end
                marcs_pkg::OP_QUERY: begin
                    hits = 0;
                    foreach (held[i]) begin
                        if (in_window(held[i].a, bounds[marcs_pkg::REG_LOWER_A],
                                      bounds[marcs_pkg::REG_UPPER_A]) &&
                            in_window(held[i].b, bounds[marcs_pkg::REG_LOWER_B],
                                      bounds[marcs_pkg::REG_UPPER_B]) &&
                            in_window(held[i].c, bounds[marcs_pkg::REG_LOWER_C],
                                      bounds[marcs_pkg::REG_UPPER_C])) begin
                            hits++;
                        end
                    end
                    due.match_count  = clamp_count(hits);
                    due.records_held = clamp_count(held.size());
                    due_counts.push_back(due);
                end
                marcs_pkg::OP_CLEAR: begin
                    held.delete();
                end
                default: begin
                end
            endcase
        endfunction

        // accepted output word against the oldest owed count
        function void check_word(input marcs_pkg::t_out_word got);
            marcs_pkg::t_out_word want;
            if (due_counts.size() == 0) begin
                $display("%0t: output word with nothing owed: match_count %0d records_held %0d",
                         $time, got.match_count, got.records_held);
                errors++;
                return;
            end
            want = due_counts.pop_front();
            if (got.match_count !== want.match_count) begin
                $display("%0t: match_count expected %0d actual %0d",
                         $time, want.match_count, got.match_count);
                errors++;
            end
            if (got.records_held !== want.records_held) begin
                $display("%0t: records_held expected %0d actual %0d",
                         $time, want.records_held, got.records_held);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [marcs_pkg::REG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [marcs_pkg::BOUND_W-1:0]   i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    marcs_pkg::t_in_word             i_in_word  = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    marcs_pkg::t_out_word            o_out_word;

    range_count_tracker            tracker = new();
    logic [marcs_pkg::BOUND_W-1:0] next_bounds[marcs_pkg::NUM_REGS];
    int                            send_idle_pct  = 0;
    int                            recv_stall_pct = 0;
    int                            quiet_cycles   = 0;

    multi_attribute_range_count_scan_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output side: check accepted words, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_word(o_out_word);
        end
        i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles where no word moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one input word, with random idle cycles ahead of it
    task automatic send_word(input logic [1:0] op, input logic [marcs_pkg::ATTR_W-1:0] a,
                             input logic [marcs_pkg::ATTR_W-1:0] b,
                             input logic [marcs_pkg::ATTR_W-1:0] c);
        marcs_pkg::t_in_word w;
        w.operation = op;
        w.attr_a    = a;
        w.attr_b    = b;
        w.attr_c    = c;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_word(w);
    endtask

    // hold the input side until every owed count is back and loads have landed
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (tracker.due_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [marcs_pkg::REG_IDX_W-1:0] idx,
                             input logic [marcs_pkg::BOUND_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    // write all bounds from next_bounds once idle, plus the unmapped indexes
    task automatic program_bounds();
        settle_idle();
        for (int i = marcs_pkg::REG_LOWER_A; i <= marcs_pkg::REG_UPPER_C; i++) begin
            write_reg(marcs_pkg::REG_IDX_W'(i), next_bounds[i]);
        end
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void set_window(input logic [marcs_pkg::REG_IDX_W-1:0] lo_idx,
                                       input logic [marcs_pkg::BOUND_W-1:0] lo,
                                       input logic [marcs_pkg::BOUND_W-1:0] hi);
        next_bounds[lo_idx]     = lo;
        next_bounds[lo_idx + 1] = hi;
    endfunction

    // random bounds pair: full, window, single point, empty, above the attribute width, fully random
    function automatic void choose_window(input logic [marcs_pkg::REG_IDX_W-1:0] lo_idx);
        logic [marcs_pkg::BOUND_W-1:0] p;
        logic [marcs_pkg::BOUND_W-1:0] q;
        logic [marcs_pkg::BOUND_W-1:0] t;
        p = $urandom_range(ATTR_TOP);
        q = $urandom_range(ATTR_TOP);
        case ($urandom_range(9))
            0, 1: begin
                p = marcs_pkg::BOUND_LOW_RST;
                q = marcs_pkg::BOUND_HIGH_RST;
            end
            6: q = p;
            7: begin
                if (p == q) begin
                    q = p + 1;
                end
                if (p < q) begin
                    t = p;
                    p = q;
                    q = t;
                end
            end
            8: begin
                p = $urandom_range(32'hffff_ffff, 32'h0100_0000);
                q = marcs_pkg::BOUND_HIGH_RST;
            end
            9: begin
                p = $urandom;
                q = $urandom;
            end
            default: begin
                if (p > q) begin
                    t = p;
                    p = q;
                    q = t;
                end
            end
        endcase
        set_window(lo_idx, p, q);
    endfunction

    // attribute value biased toward the edges and inside of a bounds pair
    function automatic logic [marcs_pkg::ATTR_W-1:0] pick_attr(
            input logic [marcs_pkg::BOUND_W-1:0] lo, input logic [marcs_pkg::BOUND_W-1:0] hi);
        logic [marcs_pkg::BOUND_W-1:0] top;
        logic [marcs_pkg::BOUND_W-1:0] v;
        top = (hi > ATTR_TOP) ? ATTR_TOP : hi;
        case ($urandom_range(9))
            0, 1: v = $urandom;
            2: v = $urandom_range(1) ? ATTR_TOP : marcs_pkg::BOUND_LOW_RST;
            3: v = lo - 1;
            4: v = hi + 1;
            5: v = lo;
            6: v = top;
            default: v = (lo <= top) ? $urandom_range(top, lo) : $urandom;
        endcase
        return v[marcs_pkg::ATTR_W-1:0];
    endfunction

    // send a word whose attributes are picked around the current bounds
    task automatic send_picked(input logic [1:0] op);
        logic [marcs_pkg::ATTR_W-1:0] a;
        logic [marcs_pkg::ATTR_W-1:0] b;
        logic [marcs_pkg::ATTR_W-1:0] c;
        a = pick_attr(tracker.bounds[marcs_pkg::REG_LOWER_A],
                      tracker.bounds[marcs_pkg::REG_UPPER_A]);
        b = pick_attr(tracker.bounds[marcs_pkg::REG_LOWER_B],
                      tracker.bounds[marcs_pkg::REG_UPPER_B]);
        c = pick_attr(tracker.bounds[marcs_pkg::REG_LOWER_C],
                      tracker.bounds[marcs_pkg::REG_UPPER_C]);
        send_word(op, a, b, c);
    endtask

    initial begin
        int         rand_words;
        int         rand_results;
        int         phase;
        int         roll;
        logic [1:0] op;

        rand_words   = 0;
        rand_results = 0;
        phase        = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extreme records, unused code, clear, reset bounds
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);
        send_word(marcs_pkg::OP_LOAD, '0, '0, '0);
        send_word(marcs_pkg::OP_LOAD, ATTR_ONES, ATTR_ONES, ATTR_ONES);
        send_word(marcs_pkg::OP_LOAD, 24'h555555, 24'haaaaaa, 24'h000001);
        send_word(marcs_pkg::OP_LOAD, 24'haaaaaa, 24'h555555, 24'hfffffe);
        send_word(OP_UNUSED, ATTR_ONES, 24'h123456, ATTR_ONES);
        send_word(marcs_pkg::OP_QUERY, ATTR_ONES, ATTR_ONES, ATTR_ONES);
        send_word(marcs_pkg::OP_CLEAR, ATTR_ONES, ATTR_ONES, ATTR_ONES);
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);
        send_word(marcs_pkg::OP_LOAD, 24'h555555, 24'h000000, 24'hffffff);
        send_word(marcs_pkg::OP_LOAD, 24'h555555, 24'haaaaaa, 24'h800000);
        send_word(marcs_pkg::OP_LOAD, 24'h555554, 24'h7fffff, 24'h000000);
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);

        // single-point first range, second range capped at the attribute width
        set_window(marcs_pkg::REG_LOWER_A, 32'h0055_5555, 32'h0055_5555);
        set_window(marcs_pkg::REG_LOWER_B, marcs_pkg::BOUND_LOW_RST, ATTR_TOP);
        set_window(marcs_pkg::REG_LOWER_C, marcs_pkg::BOUND_LOW_RST, marcs_pkg::BOUND_HIGH_RST);
        program_bounds();
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);

        // lower bound above every attribute value
        set_window(marcs_pkg::REG_LOWER_C, 32'h0100_0000, marcs_pkg::BOUND_HIGH_RST);
        program_bounds();
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);

        // empty range, lower above upper
        set_window(marcs_pkg::REG_LOWER_A, marcs_pkg::BOUND_LOW_RST, marcs_pkg::BOUND_HIGH_RST);
        set_window(marcs_pkg::REG_LOWER_B, 32'h00aa_aaaa, 32'h0055_5555);
        set_window(marcs_pkg::REG_LOWER_C, marcs_pkg::BOUND_LOW_RST, marcs_pkg::BOUND_HIGH_RST);
        program_bounds();
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);

        // exact hits on both ends of every range
        set_window(marcs_pkg::REG_LOWER_A, 32'h0055_5554, 32'h0055_5554);
        set_window(marcs_pkg::REG_LOWER_B, 32'h007f_ffff, 32'h007f_ffff);
        set_window(marcs_pkg::REG_LOWER_C, marcs_pkg::BOUND_LOW_RST, marcs_pkg::BOUND_LOW_RST);
        program_bounds();
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);

        // refill with records around the bounds, then queries under receiver stall
        set_window(marcs_pkg::REG_LOWER_A, 32'h0040_0000, 32'h00bf_ffff);
        set_window(marcs_pkg::REG_LOWER_B, marcs_pkg::BOUND_LOW_RST, 32'h007f_ffff);
        set_window(marcs_pkg::REG_LOWER_C, marcs_pkg::BOUND_LOW_RST, marcs_pkg::BOUND_HIGH_RST);
        program_bounds();
        send_word(marcs_pkg::OP_CLEAR, '0, '0, '0);
        repeat (FILL_WORDS) begin
            send_picked(marcs_pkg::OP_LOAD);
        end
        recv_stall_pct = 74;
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);
        send_word(marcs_pkg::OP_LOAD, ATTR_ONES, '0, ATTR_ONES);
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);
        send_word(marcs_pkg::OP_CLEAR, '0, '0, '0);
        send_word(marcs_pkg::OP_QUERY, '0, '0, '0);

        // random phases, fresh bounds and idling pattern per phase
        while (rand_words < RAND_WORDS || rand_results < RAND_RESULTS) begin
            choose_window(marcs_pkg::REG_LOWER_A);
            choose_window(marcs_pkg::REG_LOWER_B);
            choose_window(marcs_pkg::REG_LOWER_C);
            program_bounds();
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            repeat (PHASE_WORDS) begin
                roll = $urandom_range(99);
                if (roll < 55) begin
                    op = marcs_pkg::OP_LOAD;
                end else if (roll < 83) begin
                    op = marcs_pkg::OP_QUERY;
                end else if (roll < 90) begin
                    op = marcs_pkg::OP_CLEAR;
                end else begin
                    op = OP_UNUSED;
                end
                send_picked(op);
                if (op != OP_UNUSED) begin
                    rand_words++;
                end
                if (op == marcs_pkg::OP_QUERY) begin
                    rand_results++;
                end
                // occasional full drain in the middle of a phase
                if ($urandom_range(49) == 0) begin
                    settle_idle();
                end
            end
            phase++;
        end

        // drain and report
        settle_idle();
        if (tracker.due_counts.size() != 0) begin
            $display("%0t: %0d output words never arrived", $time, tracker.due_counts.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
